@@ hw/rtl/mfbp_pkg.sv @@
package mfbp_pkg;

	localparam int VALUE_BITS = 32;
	localparam int BYTE_BITS  = 8;
	localparam int LEN_W      = 6;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_FLUSH  = 1'b1;

	typedef struct packed {
		logic                  req_type;
		logic [VALUE_BITS-1:0] field_value;
		logic [LEN_W-1:0]      field_length;
	} req_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic                 last_byte;
	} rsp_t;

	// bytes are left aligned: first byte in data[31:24]
	typedef struct packed {
		logic [VALUE_BITS-1:0] data;
		logic [2:0]            nbytes;
	} qent_t;

	typedef struct packed {
		logic  push;
		qent_t ent;
	} qpush_t;

endpackage

@@ hw/rtl/mfbp_front.sv @@
module mfbp_front #(
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pad_bit,
	input  logic            req_valid,
	output logic            req_stall,
	input  mfbp_pkg::req_t  req,
	input  logic            q_full,
	output mfbp_pkg::qpush_t qpush
);
	import mfbp_pkg::*;

	localparam int LIMIT = (MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LIMIT);

	logic [6:0] partial_q;
	logic [2:0] count_q;

	logic                  acc;
	logic [LEN_W-1:0]      len_c;
	logic [VALUE_BITS-1:0] vmask;
	logic [38:0]           w;
	logic [5:0]            total;
	logic [39:0]           la;
	logic [6:0]            pmask;
	logic [7:0]            fbyte;
	logic [7:0]            fill;
	logic [3:0]            free_bits;
	logic [6:0]            partial_d;
	logic [2:0]            count_d;

	assign req_stall = q_full;
	assign acc       = req_valid && !req_stall;

	always_comb begin
		len_c = (req.field_length > LEN_LIMIT) ? LEN_LIMIT : req.field_length;
		vmask = (len_c == '0) ? '0 : ({VALUE_BITS{1'b1}} >> (6'd32 - len_c));
		w     = ({32'b0, partial_q} << len_c) | {7'b0, req.field_value & vmask};
		total = {3'b0, count_q} + len_c;
		// left align the pending bits so complete bytes sit at the top
		la    = {1'b0, w} << (6'd40 - total);
		pmask = 7'((8'd1 << total[2:0]) - 8'd1);

		free_bits = 4'd8 - {1'b0, count_q};
		fill      = pad_bit ? (8'hFF >> count_q) : 8'h00;
		fbyte     = 8'({1'b0, partial_q} << free_bits) | fill;

		qpush = '0;
		partial_d = partial_q;
		count_d   = count_q;
		if (req.req_type == REQ_FLUSH) begin
			qpush.push       = acc && (count_q != '0);
			qpush.ent.data   = {fbyte, 24'b0};
			qpush.ent.nbytes = 3'd1;
			partial_d = '0;
			count_d   = '0;
		end else begin
			qpush.push       = acc && (total[5:3] != '0);
			qpush.ent.data   = la[39:8];
			qpush.ent.nbytes = total[5:3];
			partial_d = w[6:0] & pmask;
			count_d   = total[2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			count_q   <= '0;
		end else if (acc) begin
			partial_q <= partial_d;
			count_q   <= count_d;
		end
	end

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		qpush.push |-> (qpush.ent.nbytes >= 3'd1 && qpush.ent.nbytes <= 3'd4))
		else $error("queued word with bad byte count");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> ($stable(partial_q) && $stable(count_q)))
		else $error("pending bits changed without an accepted word");

	a_pending_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(partial_q >> count_q) == 7'd0)
		else $error("pending bits above count not zero");

endmodule

@@ hw/rtl/mfbp_queue.sv @@
module mfbp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  mfbp_pkg::qpush_t qpush,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output mfbp_pkg::qent_t  head
);
	import mfbp_pkg::*;

	qent_t             ent_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (qpush.push) begin
			ent_q[wptr_q] <= qpush.ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (qpush.push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({qpush.push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qpush.push |-> !full)
		else $error("push into full queue");

endmodule

@@ hw/rtl/mfbp_back.sv @@
module mfbp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  mfbp_pkg::qent_t head,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output mfbp_pkg::rsp_t  rsp
);
	import mfbp_pkg::*;

	logic [1:0]            idx_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic                  load;
	logic                  last;
	logic [VALUE_BITS-1:0] sh;

	assign load = head_valid && (!rsp_valid_q || !rsp_stall);
	assign last = ({1'b0, idx_q} + 3'd1) == head.nbytes;
	assign pop  = load && last;
	assign sh   = head.data << {idx_q, 3'b000};

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q.out_byte  <= sh[31:24];
			rsp_q.last_byte <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= last ? 2'd0 : idx_q + 2'd1;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, idx_q} < head.nbytes))
		else $error("byte index past end of queued word");

endmodule

@@ hw/rtl/msb_first_bit_packer.sv @@
// MSB-first bit packer. Append words put the low field_length bits of
// field_value (clamped to MAX_FIELD_BITS, at most 32) behind the pending
// bits, highest bit first; each complete byte comes out on rsp, last_byte
// marking the final byte of a word. Flush words pad a non-empty partial
// byte with pad_bit (register 0, byte address 0) and emit it. A word is
// accepted every cycle while the two-entry queue between the packing front
// and the byte serializer has room; the serializer sends one byte per cycle
// while rsp_stall is low, so a word that completes n bytes (0 to 4) yields
// n bytes in turn, and sustained throughput without stalls is one byte per clock.
module msb_first_bit_packer #(
	parameter int MAX_FIELD_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           req_valid,
	output logic           req_stall,
	input  mfbp_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mfbp_pkg::rsp_t rsp
);
	import mfbp_pkg::*;

	localparam logic REG_PAD_BIT = 1'b0;

	logic   pad_bit_q;
	logic   q_full;
	logic   head_valid;
	logic   pop;
	qent_t  head;
	qpush_t qpush;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PAD_BIT) ? {31'b0, pad_bit_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_bit_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_PAD_BIT) begin
			pad_bit_q <= pwdata[0];
		end
	end

	mfbp_front #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pad_bit   (pad_bit_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.qpush     (qpush)
	);

	mfbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.qpush      (qpush),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	mfbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

@@ bench/msb_first_bit_packer_tb.sv @@
module msb_first_bit_packer_tb;
	import mfbp_pkg::*;

	localparam int FIELD_LIMIT = 32;
	localparam logic [2:0] PAD_BIT_ADDR = 3'd0;
	localparam int PLAN_ROWS = 24;
	localparam int RAND_PHASES = 6;
	localparam int PHASE_WORDS = 74;
	localparam int SETTLE_CYCLES = 8;
	localparam logic TYPED = 1'b1;
	localparam logic PREDICTED = 1'b0;

	// typed expectation for a directed word; bytes left aligned
	typedef struct packed {
		logic        typed;
		logic [2:0]  nbytes;
		logic [31:0] bytes;
	} tag_t;

	typedef struct packed {
		logic pad;
		req_t word;
		tag_t tag;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;

	// packer state as the bench sees it
	logic [6:0] held_bits = '0;
	logic [2:0] held_count = '0;
	logic       pad_fill = 1'b0;

	rsp_t due_bytes [$];
	tag_t word_tags [$];
	row_t plan [PLAN_ROWS];
	int   errors = 0;
	int   src_idle_pct = 0;
	int   sink_idle_pct = 0;
	int   stall_left = 0;

	msb_first_bit_packer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	// advances the held bits by one word, returns the byte count
	function automatic int pack_word(input req_t w, output logic [31:0] bytes);
		int unsigned len;
		int n;
		logic [7:0] acc;
		logic [3:0] cnt;
		bytes = '0;
		n = 0;
		if (w.req_type == REQ_FLUSH) begin
			if (held_count != 0) begin
				acc = {1'b0, held_bits} << (8 - held_count);
				if (pad_fill)
					acc = acc | (8'hFF >> held_count);
				bytes[31:24] = acc;
				n = 1;
				held_bits = '0;
				held_count = '0;
			end
		end else begin
			len = (w.field_length > FIELD_LIMIT) ? FIELD_LIMIT : w.field_length;
			acc = {1'b0, held_bits};
			cnt = {1'b0, held_count};
			while (len > 0) begin
				len--;
				acc = {acc[6:0], w.field_value[len]};
				cnt++;
				if (cnt == 4'd8) begin
					bytes[31 - 8*n -: 8] = acc;
					n++;
					acc = '0;
					cnt = '0;
				end
			end
			held_bits = acc[6:0];
			held_count = cnt[2:0];
		end
		return n;
	endfunction

	function automatic row_t row_of(input logic pad, input logic kind,
			input logic [31:0] value, input logic [5:0] len, input logic typed,
			input logic [2:0] n, input logic [31:0] bytes);
		row_t r;
		r.pad = pad;
		r.word.req_type = kind;
		r.word.field_value = value;
		r.word.field_length = len;
		r.tag.typed = typed;
		r.tag.nbytes = n;
		r.tag.bytes = bytes;
		return r;
	endfunction

	function automatic req_t random_word();
		req_t w;
		int pick;
		int shape;
		pick = $urandom_range(0, 99);
		shape = $urandom_range(0, 7);
		w.req_type = (pick < 15) ? REQ_FLUSH : REQ_APPEND;
		w.field_value = $urandom;
		if (shape == 0)
			w.field_value = '1;
		else if (shape == 1)
			w.field_value = '0;
		if (pick < 15)
			w.field_length = 6'($urandom_range(0, 63));
		else if (pick < 25)
			w.field_length = 6'($urandom_range(33, 63));
		else if (pick < 32)
			w.field_length = ($urandom_range(0, 1) != 0) ? 6'd32 : 6'd0;
		else
			w.field_length = 6'($urandom_range(1, 31));
		return w;
	endfunction

	// predict on accepted words first, so even a same-cycle byte finds its expectation
	always @(posedge clk) begin : byte_check
		tag_t t;
		logic [31:0] bytes;
		int n;
		rsp_t e;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				t = word_tags.pop_front();
				n = pack_word(req, bytes);
				if (t.typed) begin
					n = int'(t.nbytes);
					bytes = t.bytes;
				end
				for (int i = 0; i < n; i++) begin
					e.out_byte = bytes[31 - 8*i -: 8];
					e.last_byte = (i == n - 1);
					due_bytes.insert(due_bytes.size(), e);
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (due_bytes.size() == 0) begin
					report_mismatch($sformatf("byte %h with none expected", rsp.out_byte));
				end else begin
					e = due_bytes.pop_front();
					if (rsp.out_byte != e.out_byte)
						report_mismatch($sformatf("out_byte %h, expected %h",
							rsp.out_byte, e.out_byte));
					if (rsp.last_byte != e.last_byte)
						report_mismatch($sformatf("last_byte %b, expected %b on byte %h",
							rsp.last_byte, e.last_byte, e.out_byte));
				end
			end
		end
	end

	// output stalls come in bursts; each burst starts with a chance of sink_idle_pct percent
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
			stall_left <= $urandom_range(0, 16);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_word(input req_t w, input tag_t t);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		word_tags.insert(word_tags.size(), t);
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// wait for every expected byte, then let the pipe go quiet
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (due_bytes.size() != 0 || word_tags.size() != 0 || stall_left != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pad(input logic v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PAD_BIT_ADDR;
		pwdata <= {31'b0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pad_fill = v;
	endtask

	initial begin : stimulus
		int src_pct [RAND_PHASES];
		int sink_pct [RAND_PHASES];
		src_pct = '{8, 15, 3, 25, 5, 0};
		sink_pct = '{10, 4, 20, 25, 6, 0};

		plan[0]  = row_of(1'b0, REQ_FLUSH,  32'h0,        6'd0,  TYPED, 3'd0, 32'h0);
		plan[1]  = row_of(1'b0, REQ_APPEND, 32'hFFFFFFFF, 6'd0,  TYPED, 3'd0, 32'h0);
		plan[2]  = row_of(1'b0, REQ_APPEND, 32'hFFFFFFFF, 6'd32, TYPED, 3'd4, 32'hFFFFFFFF);
		plan[3]  = row_of(1'b0, REQ_APPEND, 32'h0,        6'd32, TYPED, 3'd4, 32'h0);
		// lengths past 32 clamp to 32
		plan[4]  = row_of(1'b0, REQ_APPEND, 32'h12345678, 6'd63, TYPED, 3'd4, 32'h12345678);
		plan[5]  = row_of(1'b0, REQ_APPEND, 32'hA5A5A5A5, 6'd33, TYPED, 3'd4, 32'hA5A5A5A5);
		plan[6]  = row_of(1'b0, REQ_APPEND, 32'hFFFFFF00, 6'd8,  TYPED, 3'd1, 32'h0);
		plan[7]  = row_of(1'b0, REQ_APPEND, 32'h1,        6'd1,  TYPED, 3'd0, 32'h0);
		// flush must ignore its operands
		plan[8]  = row_of(1'b0, REQ_FLUSH,  32'hDEADBEEF, 6'd40, TYPED, 3'd1, 32'h80000000);
		plan[9]  = row_of(1'b0, REQ_APPEND, 32'h5,        6'd3,  PREDICTED, 3'd0, 32'h0);
		plan[10] = row_of(1'b0, REQ_APPEND, 32'h7F,       6'd7,  PREDICTED, 3'd0, 32'h0);
		plan[11] = row_of(1'b0, REQ_FLUSH,  32'hFFFFFFFF, 6'd63, PREDICTED, 3'd0, 32'h0);
		plan[12] = row_of(1'b0, REQ_APPEND, 32'h0,        6'd7,  TYPED, 3'd0, 32'h0);
		plan[13] = row_of(1'b0, REQ_FLUSH,  32'h0,        6'd0,  TYPED, 3'd1, 32'h0);
		plan[14] = row_of(1'b1, REQ_APPEND, 32'h0,        6'd1,  TYPED, 3'd0, 32'h0);
		plan[15] = row_of(1'b1, REQ_FLUSH,  32'h0,        6'd0,  TYPED, 3'd1, 32'h7F000000);
		plan[16] = row_of(1'b1, REQ_APPEND, 32'h55,       6'd7,  TYPED, 3'd0, 32'h0);
		plan[17] = row_of(1'b1, REQ_FLUSH,  32'h0,        6'd0,  TYPED, 3'd1, 32'hAB000000);
		plan[18] = row_of(1'b1, REQ_FLUSH,  32'hFFFFFFFF, 6'd63, TYPED, 3'd0, 32'h0);
		plan[19] = row_of(1'b1, REQ_APPEND, 32'h1F,       6'd5,  PREDICTED, 3'd0, 32'h0);
		plan[20] = row_of(1'b1, REQ_APPEND, 32'h80000001, 6'd32, PREDICTED, 3'd0, 32'h0);
		plan[21] = row_of(1'b1, REQ_APPEND, 32'h0,        6'd63, PREDICTED, 3'd0, 32'h0);
		plan[22] = row_of(1'b1, REQ_APPEND, 32'hAAAAAAAA, 6'd20, PREDICTED, 3'd0, 32'h0);
		plan[23] = row_of(1'b1, REQ_FLUSH,  32'h0,        6'd0,  PREDICTED, 3'd0, 32'h0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 10;
		sink_idle_pct = 10;
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].pad != pad_fill) begin
				settle();
				write_pad(plan[i].pad);
			end
			send_word(plan[i].word, plan[i].tag);
		end

		// pad alternates per phase; the final phase runs without idling
		for (int p = 0; p < RAND_PHASES; p++) begin
			src_idle_pct = src_pct[p];
			sink_idle_pct = sink_pct[p];
			settle();
			write_pad(p % 2 != 0);
			for (int k = 0; k < PHASE_WORDS; k++)
				send_word(random_word(), '0);
		end

		settle();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/mfbp_pkg.sv
hw/rtl/mfbp_front.sv
hw/rtl/mfbp_queue.sv
hw/rtl/mfbp_back.sv
hw/rtl/msb_first_bit_packer.sv
bench/msb_first_bit_packer_tb.sv
